FILE: sv/bffa_pkg.sv
package bffa_pkg;

  localparam int unsigned MAP_BITS  = 8192;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned ADDR_W    = $clog2(MAP_WORDS);
  localparam int unsigned BIT_W     = $clog2(WORD_BITS);

  // Field widths of the ports.
  localparam int unsigned OP_W  = 2;
  localparam int unsigned IDX_W = 13;
  localparam int unsigned CNT_W = 14;
  localparam int unsigned ST_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic                 re;
    logic [ADDR_W-1:0]    raddr;
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
  } map_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } scan_t;

endpackage

FILE: sv/bffa_ram.sv
module bffa_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bffa_map.sv
module bffa_map
  import bffa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  map_req_t             req_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  // A row that was never written since reset reads as all free.
  logic [MAP_WORDS-1:0] row_vld_q;
  logic                 rvld_q;
  logic [WORD_BITS-1:0] ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rvld_q    <= 1'b0;
    end else begin
      if (req_i.we) begin
        row_vld_q[req_i.waddr] <= 1'b1;
      end
      if (req_i.re) begin
        rvld_q <= row_vld_q[req_i.raddr];
      end
    end
  end

  bffa_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(MAP_WORDS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.re),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  assign rdata_o = rvld_q ? ram_rdata : '0;

endmodule

FILE: sv/bffa_scan.sv
module bffa_scan
  import bffa_pkg::*;
(
  input  logic [WORD_BITS-1:0] word_i,
  output scan_t                res_o
);

  // Lowest clear bit wins; the loop runs high to low so the last hit is the lowest.
  always_comb begin
    res_o = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!word_i[i]) begin
        res_o.found   = 1'b1;
        res_o.bit_idx = BIT_W'(i);
      end
    end
  end

endmodule

FILE: sv/bitmap_first_free_allocator.sv
// First-fit bitmap allocator over 8192 entries, held as 256 words of 32 bits in one
// synchronous RAM with a single read and a single write port. One word is taken at a
// time: an allocate reads one bitmap word per cycle from word 0 up and reads at most
// ceil(limit / 32) words. Release and mark read the word of the index and write it
// back if the bit flips; an out-of-range index or unused opcode goes straight to the
// result. The next word is accepted once the result has moved to the output
// register. After reset the map is empty at once: per-row valid flops stand in for a
// clearing pass. entry_limit may be written only while the block is idle; values
// above 8192 act as 8192.
module bitmap_first_free_allocator
  import bffa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OP_W-1:0]  operation_i,
  input  logic [IDX_W-1:0] entry_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CNT_W-1:0] entry_number_o,
  output logic [ST_W-1:0]  status_o,
  output logic [CNT_W-1:0] used_count_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_MODIFY = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     limit_q;
  logic [CNT_W-1:0]     used_q, used_d;
  logic [OP_W-1:0]      op_q, op_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [ADDR_W-1:0]    addr_q, addr_d;
  logic [CNT_W-1:0]     res_number_q, res_number_d;
  status_e              res_status_q, res_status_d;
  logic                 out_valid_q;
  logic [CNT_W-1:0]     out_number_q;
  logic [ST_W-1:0]      out_status_q;
  logic [CNT_W-1:0]     out_used_q;
  logic                 out_load;

  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     word_end;
  logic [WORD_BITS-1:0] rword;
  logic [WORD_BITS-1:0] in_range;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 cur_bit;
  map_req_t             map_req;
  scan_t                scan;

  assign lim = (limit_q > CNT_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : limit_q;

  // First entry past the word under scan.
  assign word_end = {({1'b0, addr_q} + (ADDR_W + 1)'(1)), {BIT_W{1'b0}}};

  // Bits at or beyond the limit count as taken, so the scan never returns them.
  assign in_range = (word_end <= lim) ? '1
                  : ((WORD_BITS'(1) << lim[BIT_W-1:0]) - WORD_BITS'(1));

  assign bit_mask = WORD_BITS'(1) << idx_q[BIT_W-1:0];
  assign cur_bit  = |(rword & bit_mask);

  bffa_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .rdata_o(rword)
  );

  bffa_scan u_scan (
    .word_i(rword | ~in_range),
    .res_o (scan)
  );

  always_comb begin
    state_d      = state_q;
    used_d       = used_q;
    op_d         = op_q;
    idx_d        = idx_q;
    addr_d       = addr_q;
    res_number_d = res_number_q;
    res_status_d = res_status_q;
    map_req      = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d         = operation_i;
          idx_d        = entry_index_i;
          res_number_d = '0;
          res_status_d = ST_OK;
          case (operation_i) inside
            OP_ALLOC: begin
              if (lim == '0) begin
                res_status_d = ST_FULL;
                state_d      = S_RESP;
              end else begin
                map_req.re    = 1'b1;
                map_req.raddr = '0;
                addr_d        = '0;
                state_d       = S_SCAN;
              end
            end
            OP_RELEASE, OP_MARK: begin
              if ({1'b0, entry_index_i} >= lim) begin
                res_status_d = ST_RANGE;
                state_d      = S_RESP;
              end else begin
                map_req.re    = 1'b1;
                map_req.raddr = entry_index_i[IDX_W-1:BIT_W];
                state_d       = S_MODIFY;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (scan.found) begin
          map_req.we    = 1'b1;
          map_req.waddr = addr_q;
          map_req.wdata = rword | (WORD_BITS'(1) << scan.bit_idx);
          used_d        = used_q + CNT_W'(1);
          res_number_d  = CNT_W'({addr_q, scan.bit_idx}) + CNT_W'(1);
          res_status_d  = ST_OK;
          state_d       = S_RESP;
        end else if (word_end >= lim) begin
          res_status_d = ST_FULL;
          state_d      = S_RESP;
        end else begin
          map_req.re    = 1'b1;
          map_req.raddr = addr_q + ADDR_W'(1);
          addr_d        = addr_q + ADDR_W'(1);
        end
      end
      S_MODIFY: begin
        map_req.waddr = idx_q[IDX_W-1:BIT_W];
        // Only an actual bit flip touches the map and the count.
        if (op_q == OP_RELEASE && cur_bit) begin
          map_req.we    = 1'b1;
          map_req.wdata = rword & ~bit_mask;
          used_d        = used_q - CNT_W'(1);
        end else if (op_q == OP_MARK && !cur_bit) begin
          map_req.we    = 1'b1;
          map_req.wdata = rword | bit_mask;
          used_d        = used_q + CNT_W'(1);
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= CNT_W'(MAP_BITS);
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    idx_q        <= idx_d;
    addr_q       <= addr_d;
    res_number_q <= res_number_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_number_q <= res_number_q;
      out_status_q <= res_status_q;
      out_used_q   <= used_q;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign entry_number_o = out_number_q;
  assign status_o       = out_status_q;
  assign used_count_o   = out_used_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("state register lost its one-hot code");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CNT_W'(MAP_BITS))
    else $error("used count exceeds the map size");

  a_idle_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |=> $stable(used_q))
    else $error("used count changed without a map update");

  a_fail_no_number: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> entry_number_o == '0)
    else $error("failed request carries an entry number");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word accepted while one is in flight");

endmodule
